[sv/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[sv/fvsd_pkg.sv]
`timescale 1ns / 1ps
package fvsd_pkg;
   localparam int Q_BITS_DEF = 15;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [1:0] CSR_VS_MAX = 2'd0;
   localparam logic [1:0] CSR_DEAD_COMP = 2'd1;
   localparam logic [1:0] CSR_PWM_PERIOD = 2'd2;
   typedef enum logic [1:0] {ST_IDLE, ST_ROOT, ST_OUT} front_state_type;
   typedef struct packed {
      logic signed [15:0] vd;
      logic signed [15:0] vq;
      logic signed [15:0] sin_theta;
      logic signed [15:0] cos_theta;
   } limited_word_type;
endpackage

[sv/fvsd_front.sv]
`timescale 1ns / 1ps
module fvsd_front (
   input  logic clock,
   input  logic reset,
   input  logic [14:0] vs_max,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_vd,
   input  logic signed [15:0] req_vq_request,
   input  logic signed [15:0] req_sin_theta,
   input  logic signed [15:0] req_cos_theta,
   output logic out_valid,
   input  logic out_ready,
   output fvsd_pkg::limited_word_type out_word
);
   import fvsd_pkg::*;
   front_state_type state_ff, state_in;
   limited_word_type word_ff;
   logic [31:0] rem_ff;
   logic [31:0] root_ff;
   logic [31:0] bit_ff;
   logic [4:0] step_ff;
   logic signed [31:0] vd2, vs2;
   logic [31:0] trial;
   logic signed [16:0] lim, vqx;
   logic take;

   assign vd2 = req_vd * req_vd;
   assign vs2 = $signed({17'd0, vs_max}) * $signed({17'd0, vs_max});
   assign trial = root_ff + bit_ff;
   assign lim = $signed({1'b0, root_ff[15:0]});
   assign vqx = (word_ff.vq > lim) ? lim : ((word_ff.vq < -lim) ? -lim : 17'(word_ff.vq));
   assign take = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_ROOT;
         ST_ROOT: if (step_ff == 5'd0) state_in = ST_OUT;
         ST_OUT: if (out_ready) state_in = req_valid ? ST_ROOT : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_OUT) && out_ready);
      out_valid = (state_ff == ST_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      if (take) begin
         word_ff <= '{req_vd, req_vq_request, req_sin_theta, req_cos_theta};
         rem_ff <= (vd2 < vs2) ? 32'(vs2 - vd2) : 32'd0;
         root_ff <= '0;
         bit_ff <= 32'h1000_0000;
         step_ff <= 5'd14;
      end else if (state_ff == ST_ROOT) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         step_ff <= step_ff - 5'd1;
      end
   end

   always_comb begin
      out_word = word_ff;
      out_word.vq = vqx[15:0];
   end

   `include "assert_macros.svh"
   `ASSERT_IMPL(a_excl, clock, reset, req_ready && out_valid, out_ready)
   `ASSERT_NEXT(a_hold, clock, reset, out_valid && !out_ready, out_valid)
   `ASSERT_NEXT(a_go, clock, reset, req_valid && req_ready, state_ff == ST_ROOT)
endmodule

[sv/fvsd_queue.sv]
`timescale 1ns / 1ps
module fvsd_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  fvsd_pkg::limited_word_type in_word,
   output logic out_valid,
   input  logic out_ready,
   output fvsd_pkg::limited_word_type out_word
);
   import fvsd_pkg::*;
   limited_word_type mem_ff [QUEUE_DEPTH];
   logic rd_ff, wr_ff;
   logic [1:0] cnt_ff;
   logic push, pop;
   assign in_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_word = mem_ff[rd_ff];
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wr_ff] <= in_word;
   end
endmodule

[sv/fvsd_back.sv]
`timescale 1ns / 1ps
module fvsd_back #(
   parameter int Q_BITS = fvsd_pkg::Q_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [11:0] dead_comp,
   input  logic [15:0] pwm_period,
   input  logic in_valid,
   output logic in_ready,
   input  fvsd_pkg::limited_word_type in_word,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_duty_a,
   output logic [15:0] rsp_duty_b,
   output logic [15:0] rsp_duty_c,
   output logic signed [15:0] rsp_vq_limited
);
   import fvsd_pkg::*;
   localparam logic signed [23:0] K23 = 24'((64'sd2 <<< Q_BITS) / 3);
   localparam logic signed [23:0] K13 = 24'((64'sd1 <<< Q_BITS) / 3);
   localparam logic signed [23:0] KS3 = 24'((64'sd1000 <<< Q_BITS) / 1732);
   localparam logic signed [23:0] KH = 24'(64'sd1 <<< (Q_BITS - 1));
   // stage valids: v_ff bits 0 park, 1 clarke, 2 inject, 3 scale; out_v_ff 4 out
   logic [3:0] v_ff;
   logic adv;
   logic signed [15:0] vq_ff [4];
   logic signed [23:0] al_ff, be_ff;
   logic signed [23:0] p_ff [3], q_ff [3];
   logic [15:0] d_ff [3];
   logic signed [23:0] ph [3], mx, mn, com;
   logic signed [40:0] dm [3];
   logic [15:0] dc [3];
   logic out_v_ff;

   function automatic logic signed [23:0] fs(input logic signed [47:0] x);
      return 24'(x >>> Q_BITS);
   endfunction

   assign adv = !out_v_ff || rsp_ready;
   assign in_ready = adv;
   assign ph[0] = fs(al_ff * K23);
   assign ph[1] = -fs(al_ff * K13) + fs(be_ff * KS3);
   assign ph[2] = -fs(al_ff * K13) - fs(be_ff * KS3);
   always_comb begin
      mx = p_ff[0]; mn = p_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (p_ff[i] > mx) mx = p_ff[i];
         if (p_ff[i] < mn) mn = p_ff[i];
      end
      com = 24'((25'(mx) + 25'(mn)) >>> 1);
      for (int i = 0; i < 3; i++) begin
         dm[i] = (41'(q_ff[i] + KH) * 41'($signed({1'b0, pwm_period}))) >>> Q_BITS;
         if (dm[i] < 0) dc[i] = '0;
         else if (dm[i] > $signed({25'd0, pwm_period})) dc[i] = pwm_period;
         else dc[i] = dm[i][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], in_valid};
         out_v_ff <= v_ff[3];
      end
      if (adv) begin
         vq_ff[0] <= in_word.vq;
         for (int i = 1; i < 4; i++) vq_ff[i] <= vq_ff[i-1];
         al_ff <= fs(in_word.vd * in_word.cos_theta) - fs(in_word.vq * in_word.sin_theta);
         be_ff <= fs(in_word.vq * in_word.cos_theta) + fs(in_word.vd * in_word.sin_theta);
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= ph[i];
            q_ff[i] <= ((p_ff[i] > 0) ? p_ff[i] + 24'(dead_comp)
                                       : p_ff[i] - 24'(dead_comp)) - com;
            d_ff[i] <= dc[i];
         end
         rsp_duty_a <= d_ff[0];
         rsp_duty_b <= d_ff[1];
         rsp_duty_c <= d_ff[2];
         rsp_vq_limited <= vq_ff[3];
      end
   end
   assign rsp_valid = out_v_ff;

   `include "assert_macros.svh"
   `ASSERT_NEXT(a_stall, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPL(a_cap_a, clock, reset, rsp_valid, rsp_duty_a <= pwm_period)
   `ASSERT_IMPL(a_cap_b, clock, reset, rsp_valid, rsp_duty_b <= pwm_period)
endmodule

[sv/foc_voltage_to_svpwm_duty_unit.sv]
`timescale 1ns / 1ps
// One word in gives one word out. The front limits vq with a 15-step bit-pair
// square root and takes the next request in the cycle it hands the previous
// one on, so it takes no new request while a root is in progress; a two-entry
// queue feeds a five-stage back pipeline (inverse Park, inverse Clarke,
// min-max injection with dead-time offset, duty scaling, output register).
module foc_voltage_to_svpwm_duty_unit #(
   parameter int Q_BITS = fvsd_pkg::Q_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_vd,
   input  logic signed [15:0] req_vq_request,
   input  logic signed [15:0] req_sin_theta,
   input  logic signed [15:0] req_cos_theta,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_duty_a,
   output logic [15:0] rsp_duty_b,
   output logic [15:0] rsp_duty_c,
   output logic signed [15:0] rsp_vq_limited
);
   import fvsd_pkg::*;
   logic [14:0] vs_max_ff;
   logic [11:0] dead_comp_ff;
   logic [15:0] pwm_period_ff;
   logic fv, fr, bv, br;
   limited_word_type fw, bw;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vs_max_ff <= 15'd28646;
         dead_comp_ff <= 12'd0;
         pwm_period_ff <= 16'd3000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_VS_MAX: vs_max_ff <= csr_data[14:0];
            CSR_DEAD_COMP: dead_comp_ff <= csr_data[11:0];
            CSR_PWM_PERIOD: pwm_period_ff <= csr_data;
            default: ;
         endcase
      end
   end
   fvsd_front u_front (.clock, .reset, .vs_max(vs_max_ff), .req_valid, .req_ready,
      .req_vd, .req_vq_request, .req_sin_theta, .req_cos_theta,
      .out_valid(fv), .out_ready(fr), .out_word(fw));
   fvsd_queue u_queue (.clock, .reset, .in_valid(fv), .in_ready(fr), .in_word(fw),
      .out_valid(bv), .out_ready(br), .out_word(bw));
   fvsd_back #(.Q_BITS(Q_BITS)) u_back (.clock, .reset, .dead_comp(dead_comp_ff),
      .pwm_period(pwm_period_ff), .in_valid(bv), .in_ready(br), .in_word(bw),
      .rsp_valid, .rsp_ready, .rsp_duty_a, .rsp_duty_b, .rsp_duty_c, .rsp_vq_limited);
endmodule
